[rtl/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rsnh_pkg.sv]
package rsnh_pkg;

    localparam int MaxEdgesDef  = 256;
    localparam int MaxCullDef   = 4;
    localparam int CoordBitsDef = 32;
    localparam int EdgeCntBits  = 9;

    typedef enum logic [1:0] {
        REQ_LOAD_EDGE = 2'd0,
        REQ_LOAD_CULL = 2'd1,
        REQ_CAST      = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CULL,
        ST_READ,
        ST_GEOM,
        ST_MULT,
        ST_PROD,
        ST_DIV,
        ST_HITP,
        ST_HSUM,
        ST_HITS,
        ST_BOX,
        ST_MISS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         slot;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic [2:0]         cull_used;
    } req_word_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] edge_a_x;
        logic signed [31:0] edge_a_y;
        logic signed [31:0] edge_b_x;
        logic signed [31:0] edge_b_y;
    } res_word_t;

endpackage

[rtl/ray_segment_nearest_hit.sv]
// Nearest ray / wall-edge hit.
// Channels: req/start/busy command port; a word is taken when start is high
// and busy is low. Load-edge and load-cull words write one table slot, if in range, and
// give no result. A cast word walks edges 0..min(edge_count, MAX_EDGES)-1 and gives one
// result word on res, marked by done for exactly one cycle.
// Configuration: cfg_valid/cfg_ready write edge_count; ready while idle.
// Flow: a load writes its slot at the accepting edge and leaves busy low.
// A cast holds busy while it reads the cull table and walks the edges; per
// walked edge, one that is culled or fails the sign tests is dropped after
// the products, one whose quotient is out of range after the divide, and
// the rest reach the box test; done rises in the same cycle that busy falls.
// The radix-2 restoring divider gives one quotient bit per cycle over 128
// bits. One cast at a time; the next word may be taken in the cycle that
// shows done.
// Reset: edge_count clears, the controller returns to idle; table contents
// stay undefined until written.
// The receiver cannot stall: done marks each result for one cycle only.
module ray_segment_nearest_hit
    import rsnh_pkg::*;
#(
    parameter int MAX_EDGES = MaxEdgesDef,
    parameter int MAX_CULL  = MaxCullDef
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  req_word_t              req,
    output logic                   done,
    output res_word_t              res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [EdgeCntBits-1:0] cfg_data
);

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = (MAX_CULL > 1) ? $clog2(MAX_CULL) : 1;
    localparam int AFRAC = 29;

    logic [127:0] edge_mem [MAX_EDGES];
    logic [127:0] cull_mem [MAX_CULL];
    logic [127:0] edge_rd_reg;
    logic [127:0] cull_rd_reg;

    state_t state_reg, state_next;
    logic [EdgeCntBits-1:0] edge_count_reg;
    logic [EW:0] idx_reg, idx_next;
    logic [CW:0] ck_reg, ck_next;
    logic [EW:0] n_edges;
    logic [CW:0] n_cull;
    logic [MAX_CULL-1:0] cull_hit_reg;

    logic signed [31:0] ox_reg, oy_reg, dx_reg, dy_reg;
    logic [2:0] cu_reg;

    logic signed [32:0] mx_reg, my_reg, sx_reg, sy_reg;
    logic signed [65:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [127:0] num_reg, rem_reg, quo_reg, dvs_reg;
    logic [7:0] dcnt_reg;
    logic signed [63:0] hxl_reg, hxh_reg, hyl_reg, hyh_reg;
    logic signed [95:0] hx_reg, hy_reg;
    logic signed [95:0] ix_reg, iy_reg;
    logic [61:0] bestq_reg;
    logic found_reg;
    res_word_t best_reg;
    res_word_t res_reg;
    logic done_reg;

    logic acc;
    assign acc = start && !busy;
    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done = done_reg;
    assign res = res_reg;

    assign n_edges = (edge_count_reg > EdgeCntBits'(MAX_EDGES)) ?
                     (EW+1)'(MAX_EDGES) : (EW+1)'(edge_count_reg);
    assign n_cull = ({29'd0, cu_reg} > MAX_CULL) ? (CW+1)'(MAX_CULL) : (CW+1)'(cu_reg);

    // memories: one write, one registered read each
    logic ewr, cwr;
    assign ewr = acc && req.req_type == REQ_LOAD_EDGE && ({24'd0, req.slot} < MAX_EDGES);
    assign cwr = acc && req.req_type == REQ_LOAD_CULL && ({24'd0, req.slot} < MAX_CULL);

    always_ff @(posedge clk)
    begin
        if (ewr)
            edge_mem[req.slot[EW-1:0]] <= {req.point_a_x, req.point_a_y,
                                           req.point_b_x, req.point_b_y};
        edge_rd_reg <= edge_mem[idx_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cwr)
            cull_mem[req.slot[CW-1:0]] <= {req.point_a_x, req.point_a_y,
                                           req.point_b_x, req.point_b_y};
        cull_rd_reg <= cull_mem[ck_reg[CW-1:0]];
    end

    logic signed [31:0] eax, eay, ebx, eby;
    assign eax = edge_rd_reg[127:96];
    assign eay = edge_rd_reg[95:64];
    assign ebx = edge_rd_reg[63:32];
    assign eby = edge_rd_reg[31:0];

    logic signed [66:0] den, side;
    assign den  = 67'(p1_reg) - 67'(p2_reg);
    assign side = 67'(p3_reg) + 67'(p4_reg);

    logic culled;
    assign culled = |cull_hit_reg;

    logic [128:0] rtry;
    assign rtry = {rem_reg, num_reg[127]} - {1'b0, dvs_reg};

    logic signed [31:0] bxlo, bxhi, bylo, byhi;
    assign bxlo = (eax < ebx) ? eax : ebx;
    assign bxhi = (eax > ebx) ? eax : ebx;
    assign bylo = (eay < eby) ? eay : eby;
    assign byhi = (eay > eby) ? eay : eby;
    logic inbox;
    assign inbox = !(ix_reg < 96'(bxlo) || ix_reg > 96'(bxhi) ||
                     iy_reg < 96'(bylo) || iy_reg > 96'(byhi));

    logic signed [42:0] farx, fary;
    assign farx = 43'(ox_reg) + 43'(dx_reg) * 43'sd1000;
    assign fary = 43'(oy_reg) + 43'(dy_reg) * 43'sd1000;
    function automatic logic [31:0] sat32(input logic signed [42:0] v);
        logic [31:0] r;
        if (v > 43'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -43'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        ck_next = ck_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && req.req_type == REQ_CAST)
                begin
                    state_next = ST_CULL;
                    idx_next = '0;
                    ck_next = '0;
                end
            end
            ST_CULL:
            begin
                // step the cull address, then start the edge walk
                if (ck_reg == (CW+1)'(MAX_CULL))
                begin
                    state_next = ST_READ;
                end
                else
                    ck_next = ck_reg + 1'b1;
            end
            ST_READ:
                state_next = (idx_reg == n_edges) ? ST_MISS : ST_GEOM;
            ST_GEOM:
                state_next = ST_MULT;
            ST_MULT:
                state_next = ST_PROD;
            ST_PROD:
            begin
                if (culled || !den[66] || side[66])
                begin
                    state_next = ST_READ;
                    idx_next = idx_reg + 1'b1;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dcnt_reg == 8'd127)
                    state_next = ST_HITP;
            end
            ST_HITP:
            begin
                if (quo_reg[127:62] != '0)
                begin
                    state_next = ST_READ;
                    idx_next = idx_reg + 1'b1;
                end
                else
                    state_next = ST_HSUM;
            end
            ST_HSUM:
                state_next = ST_HITS;
            ST_HITS:
                state_next = ST_BOX;
            ST_BOX:
            begin
                state_next = ST_READ;
                idx_next = idx_reg + 1'b1;
            end
            ST_MISS:
                state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            ck_reg <= '0;
            edge_count_reg <= '0;
            done_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            ck_reg <= ck_next;
            if (cfg_valid && cfg_ready)
                edge_count_reg <= cfg_data;
            done_reg <= (state_reg == ST_DONE);
            if (state_reg == ST_IDLE)
                found_reg <= 1'b0;
            else if (state_reg == ST_BOX && inbox &&
                     (!found_reg || quo_reg[61:0] < bestq_reg))
                found_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ox_reg <= req.origin_x;
                oy_reg <= req.origin_y;
                dx_reg <= req.dir_x;
                dy_reg <= req.dir_y;
                cu_reg <= req.cull_used;
            end
            ST_GEOM:
            begin
                mx_reg <= 33'(ebx) - 33'(eax);
                my_reg <= 33'(eby) - 33'(eay);
                sx_reg <= 33'(ox_reg) - 33'(eax);
                sy_reg <= 33'(oy_reg) - 33'(eay);
            end
            ST_PROD:
            begin
                rem_reg <= '0;
                quo_reg <= '0;
                dcnt_reg <= '0;
                num_reg <= 128'($unsigned(side)) << AFRAC;
                dvs_reg <= 128'($unsigned(-den));
            end
            ST_DIV:
            begin
                if (!rtry[128])
                begin
                    rem_reg <= rtry[127:0];
                    quo_reg <= {quo_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[126:0], num_reg[127]};
                    quo_reg <= {quo_reg[126:0], 1'b0};
                end
                num_reg <= {num_reg[126:0], 1'b0};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            ST_HITP:
            begin
                // split the 62-bit quotient into two 31-bit halves
                hxl_reg <= 64'($signed({1'b0, quo_reg[30:0]})) * 64'(dx_reg);
                hxh_reg <= 64'($signed({1'b0, quo_reg[61:31]})) * 64'(dx_reg);
                hyl_reg <= 64'($signed({1'b0, quo_reg[30:0]})) * 64'(dy_reg);
                hyh_reg <= 64'($signed({1'b0, quo_reg[61:31]})) * 64'(dy_reg);
            end
            ST_HSUM:
            begin
                hx_reg <= (96'(hxh_reg) <<< 31) + 96'(hxl_reg);
                hy_reg <= (96'(hyh_reg) <<< 31) + 96'(hyl_reg);
            end
            ST_HITS:
            begin
                ix_reg <= 96'(ox_reg) + (hx_reg >>> AFRAC);
                iy_reg <= 96'(oy_reg) + (hy_reg >>> AFRAC);
            end
            ST_BOX:
            begin
                if (inbox && (!found_reg || quo_reg[61:0] < bestq_reg))
                begin
                    bestq_reg <= quo_reg[61:0];
                    best_reg.hit <= 1'b1;
                    best_reg.hit_x <= ix_reg[31:0];
                    best_reg.hit_y <= iy_reg[31:0];
                    best_reg.edge_a_x <= eax;
                    best_reg.edge_a_y <= eay;
                    best_reg.edge_b_x <= ebx;
                    best_reg.edge_b_y <= eby;
                end
            end
            ST_MISS:
            begin
                if (found_reg)
                    res_reg <= best_reg;
                else
                begin
                    res_reg.hit <= 1'b0;
                    res_reg.hit_x <= sat32(farx);
                    res_reg.hit_y <= sat32(fary);
                    res_reg.edge_a_x <= '0;
                    res_reg.edge_a_y <= '0;
                    res_reg.edge_b_x <= '0;
                    res_reg.edge_b_y <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // cull compare registered in GEOM, cross products in MULT
    logic [MAX_CULL-1:0] cmatch_reg;
    always_ff @(posedge clk)
    begin
        // read data is registered, so it lags the address
        if (state_reg == ST_CULL && ck_reg != '0)
            cmatch_reg[ck_reg[CW-1:0] - 1'b1] <= ((ck_reg - 1'b1) < n_cull);
    end

    logic signed [65:0] m1, m2, m3, m4;
    assign m1 = 66'(dy_reg) * 66'(mx_reg);
    assign m2 = 66'(dx_reg) * 66'(my_reg);
    assign m3 = 66'(sx_reg) * (-66'(my_reg));
    assign m4 = 66'(sy_reg) * 66'(mx_reg);

    logic [127:0] cull_vec [MAX_CULL];
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CULL && ck_reg != '0)
            cull_vec[ck_reg[CW-1:0] - 1'b1] <= cull_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GEOM)
        begin
            for (int k = 0; k < MAX_CULL; k++)
                cull_hit_reg[k] <= cmatch_reg[k] && (cull_vec[k] == edge_rd_reg);
        end
    end

    logic prod_go;
    assign prod_go = (state_reg == ST_MULT);
    always_ff @(posedge clk)
    begin
        if (prod_go)
        begin
            p1_reg <= m1;
            p2_reg <= m2;
            p3_reg <= m3;
            p4_reg <= m4;
        end
    end

endmodule

[rtl/rsnh_checker.sv]
`include "assert_macros.svh"
module rsnh_checker
    import rsnh_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);
    `CHK_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held two cycles")
    `CHK_IMPLY(a_done_busy_off, clk, rst_n, done, !busy, "done while busy")
    `CHK_IMPLY(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready, !busy, "config write while busy")
    `CHK_IMPLY(a_done_prev_busy, clk, rst_n, done, $past(busy), "done without prior work")
    `CHK_NEXT(a_idle_hold, clk, rst_n, !busy && !start, !busy, "busy without a word")
endmodule

bind ray_segment_nearest_hit rsnh_checker u_rsnh_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

[test/tb_ray_segment_nearest_hit.sv]
`timescale 1ns / 1ps

module tb_ray_segment_nearest_hit;
    import rsnh_pkg::*;

    localparam int          NumEdges    = 256;
    localparam int          NumCull     = 4;
    localparam int          Afrac       = 29;
    localparam int          SceneEdges  = 16;
    localparam longint      CycleLimit  = 3000000;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } seg_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    req_word_t              req;
    logic                   done;
    res_word_t              res;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [EdgeCntBits-1:0] cfg_data;

    seg_t                   wall_mdl [NumEdges];
    seg_t                   cull_mdl [NumCull];
    logic [EdgeCntBits-1:0] walk_count;
    res_word_t              pending_hits [$];
    int                     errors;
    int                     n_loads;
    int                     n_casts;
    int                     n_hits;
    int                     n_seen;
    longint                 cycles;
    bit                     idle_on;

    ray_segment_nearest_hit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("ray_segment_nearest_hit: mismatch");
            $finish;
        end
    end

    function automatic logic signed [31:0] fix(input int n);
        return 32'(n) <<< 16;
    endfunction

    // small coordinate around the origin, random fraction
    function automatic logic signed [31:0] near_coord();
        return 32'($urandom_range(0, 200 << 16)) - (100 << 16);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic res_word_t nearest_hit(input req_word_t w);
        res_word_t               r;
        logic signed [127:0]     ox, oy, dx, dy, ax, ay, bx, by, mx, my;
        logic signed [127:0]     den, side, q, ix, iy, best;
        logic signed [63:0]      far_x, far_y;
        int                      ncull, nwalk;
        bit                      culled, found;
        seg_t                    s;

        r = '0;
        found = 1'b0;
        best = '0;
        ox = w.origin_x;
        oy = w.origin_y;
        dx = w.dir_x;
        dy = w.dir_y;
        ncull = (w.cull_used > NumCull) ? NumCull : int'(w.cull_used);
        nwalk = (walk_count > NumEdges) ? NumEdges : int'(walk_count);
        for (int i = 0; i < nwalk; i++)
        begin
            s = wall_mdl[i];
            culled = 1'b0;
            for (int k = 0; k < ncull; k++)
                if (cull_mdl[k] == s)
                    culled = 1'b1;
            if (culled)
                continue;
            ax = s.ax;
            ay = s.ay;
            bx = s.bx;
            by = s.by;
            mx = bx - ax;
            my = by - ay;
            den = dy * mx - dx * my;
            if (den >= 0)
                continue;
            side = (ox - ax) * (-my) + (oy - ay) * mx;
            if (side < 0)
                continue;
            q = (side <<< Afrac) / (-den);
            if (q >= (128'sd1 <<< 62))
                continue;
            ix = ox + ((q * dx) >>> Afrac);
            iy = oy + ((q * dy) >>> Afrac);
            if (ix < ((ax < bx) ? ax : bx) || ix > ((ax > bx) ? ax : bx) ||
                iy < ((ay < by) ? ay : by) || iy > ((ay > by) ? ay : by))
                continue;
            // strictly nearer only, so the lower index keeps a tie
            if (!found || q < best)
            begin
                found = 1'b1;
                best = q;
                r.hit_x = ix[31:0];
                r.hit_y = iy[31:0];
                r.edge_a_x = s.ax;
                r.edge_a_y = s.ay;
                r.edge_b_x = s.bx;
                r.edge_b_y = s.by;
            end
        end
        if (found)
            r.hit = 1'b1;
        else
        begin
            far_x = 64'(w.origin_x) + 64'(w.dir_x) * 64'sd1000;
            far_y = 64'(w.origin_y) + 64'(w.dir_y) * 64'sd1000;
            r.hit_x = sat32(far_x);
            r.hit_y = sat32(far_y);
        end
        return r;
    endfunction

    task automatic account_word(input req_word_t w);
        res_word_t r;
        case (w.req_type)
            REQ_LOAD_EDGE:
            begin
                wall_mdl[w.slot] = {w.point_a_x, w.point_a_y, w.point_b_x, w.point_b_y};
                n_loads++;
            end
            REQ_LOAD_CULL:
            begin
                if (w.slot < NumCull)
                    cull_mdl[w.slot] = {w.point_a_x, w.point_a_y, w.point_b_x, w.point_b_y};
                n_loads++;
            end
            REQ_CAST:
            begin
                r = nearest_hit(w);
                pending_hits.push_back(r);
                n_casts++;
                if (r.hit)
                    n_hits++;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input req_word_t w);
        @(negedge clk);
        start = 1'b1;
        req = w;
        do
            @(posedge clk);
        while (busy);
        account_word(w);
    endtask

    task automatic maybe_idle();
        int n;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 13);
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        // loads and ignored words give no result; let the block settle
        repeat (10)
            @(posedge clk);
    endtask

    task automatic write_edge_count(input int n);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = n[EdgeCntBits-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        walk_count = n[EdgeCntBits-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic req_word_t edge_word(input int slot, input seg_t s);
        req_word_t w;
        w = '0;
        w.req_type = REQ_LOAD_EDGE;
        w.slot = slot[7:0];
        {w.point_a_x, w.point_a_y, w.point_b_x, w.point_b_y} = s;
        return w;
    endfunction

    function automatic req_word_t cull_word(input int slot, input seg_t s);
        req_word_t w;
        w = edge_word(slot, s);
        w.req_type = REQ_LOAD_CULL;
        return w;
    endfunction

    function automatic req_word_t cast_word(input logic signed [31:0] ox, oy, dx, dy,
                                            input int nc);
        req_word_t w;
        w = '0;
        w.req_type = REQ_CAST;
        w.origin_x = ox;
        w.origin_y = oy;
        w.dir_x = dx;
        w.dir_y = dy;
        w.cull_used = nc[2:0];
        return w;
    endfunction

    function automatic seg_t near_seg();
        return {near_coord(), near_coord(), near_coord(), near_coord()};
    endfunction

    function automatic req_word_t near_cast();
        return cast_word(near_coord() >>> 2, near_coord() >>> 2,
                         near_coord() >>> 4, near_coord() >>> 4, $urandom_range(0, 7));
    endfunction

    always @(posedge clk)
    begin
        res_word_t e;
        if (rst_n && done)
        begin
            n_seen++;
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result word hit=%0d x=%h y=%h", res.hit, res.hit_x,
                       res.hit_y);
                errors++;
            end
            else
            begin
                e = pending_hits.pop_front();
                if (res.hit !== e.hit)
                begin
                    $error("hit: expected %0d, got %0d", e.hit, res.hit);
                    errors++;
                end
                if (res.hit_x !== e.hit_x)
                begin
                    $error("hit_x: expected %h, got %h", e.hit_x, res.hit_x);
                    errors++;
                end
                if (res.hit_y !== e.hit_y)
                begin
                    $error("hit_y: expected %h, got %h", e.hit_y, res.hit_y);
                    errors++;
                end
                if (res.edge_a_x !== e.edge_a_x)
                begin
                    $error("edge_a_x: expected %h, got %h", e.edge_a_x, res.edge_a_x);
                    errors++;
                end
                if (res.edge_a_y !== e.edge_a_y)
                begin
                    $error("edge_a_y: expected %h, got %h", e.edge_a_y, res.edge_a_y);
                    errors++;
                end
                if (res.edge_b_x !== e.edge_b_x)
                begin
                    $error("edge_b_x: expected %h, got %h", e.edge_b_x, res.edge_b_x);
                    errors++;
                end
                if (res.edge_b_y !== e.edge_b_y)
                begin
                    $error("edge_b_y: expected %h, got %h", e.edge_b_y, res.edge_b_y);
                    errors++;
                end
            end
        end
    end

    // no edges walked: far point, saturated at the range ends
    task automatic test_empty_table();
        send_word(cast_word(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0));
        send_word(cast_word(fix(3), fix(-2), fix(1), 32'h00008000, 4));
    endtask

    task automatic test_directed_scene();
        seg_t wall;
        wall = {fix(10), fix(-10), fix(10), fix(10)};
        send_word(edge_word(0, wall));
        send_word(edge_word(1, {wall.bx, wall.by, wall.ax, wall.ay}));   // faces away
        send_word(edge_word(2, {fix(-5), fix(0), fix(5), fix(0)}));      // parallel
        send_word(edge_word(3, {32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff}));
        send_word(edge_word(4, wall));                                  // tie with slot 0
        for (int i = 5; i < SceneEdges; i++)
            send_word(edge_word(i, near_seg()));
        send_word(cull_word(0, wall));
        for (int i = 1; i < NumCull; i++)
            send_word(cull_word(i, near_seg()));
        write_edge_count(SceneEdges);
        send_word(cast_word(fix(0), fix(0), fix(1), fix(0), 0));
        send_word(cast_word(fix(0), fix(0), fix(1), fix(0), 1));        // cull both copies
        send_word(cast_word(fix(0), fix(0), fix(1), fix(0), 7));
        send_word(cast_word(fix(0), fix(0), fix(0), fix(0), 0));        // null direction
        send_word(cast_word(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0));
        send_word(cast_word(fix(20), fix(0), fix(-1), fix(0), 0));      // from behind
    endtask

    task automatic test_ignored_words();
        req_word_t w;
        w = cull_word(5, {fix(1), fix(1), fix(2), fix(2)});
        send_word(w);
        w.req_type = REQ_NONE;
        w.slot = 8'hff;
        send_word(w);
        send_word(cast_word(fix(0), fix(0), fix(1), fix(0), 0));
    endtask

    task automatic test_full_table();
        for (int i = SceneEdges; i < NumEdges; i++)
            send_word(edge_word(i, near_seg()));
        write_edge_count(NumEdges);
        send_word(near_cast());
        write_edge_count(511);
        send_word(near_cast());
        write_edge_count(SceneEdges);
    endtask

    task automatic test_random_traffic(input int n);
        req_word_t    w;
        int           pick;
        logic [319:0] noise;
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 80)
                idle_on = 1'b0;
            if (i % 60 == 59)
                write_edge_count($urandom_range(0, SceneEdges));
            if (i == n / 2)
                drain();
            maybe_idle();
            pick = $urandom_range(0, 99);
            if (pick < 25)
                w = edge_word($urandom_range(0, SceneEdges - 1), near_seg());
            else if (pick < 35)
                w = cull_word($urandom_range(0, 7),
                              wall_mdl[$urandom_range(0, SceneEdges - 1)]);
            else if (pick < 85)
                w = near_cast();
            else
            begin
                // full-range noise of any kind; edge loads stay inside the walked scene
                noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom};
                w = noise[$bits(req_word_t)-1:0];
                if (w.req_type == REQ_LOAD_EDGE)
                    w.slot[7:4] = 4'd0;
            end
            send_word(w);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        walk_count = '0;
        errors = 0;
        n_loads = 0;
        n_casts = 0;
        n_hits = 0;
        n_seen = 0;
        cycles = 0;
        idle_on = 1'b1;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_directed_scene();
        test_ignored_words();
        test_full_table();
        test_random_traffic(250);

        drain();
        repeat (200)
            @(posedge clk);
        $display("covered %0d table loads and %0d casts (%0d hits, %0d results seen)",
                 n_loads, n_casts, n_hits, n_seen);
        $display("edge counts 0 to 511, cull counts 0 to 7, ignored words, idle bursts");
        if (errors == 0 && pending_hits.size() == 0)
            $display("ray_segment_nearest_hit: match");
        else
            $display("ray_segment_nearest_hit: mismatch");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/rsnh_pkg.sv
rtl/ray_segment_nearest_hit.sv
rtl/rsnh_checker.sv
test/tb_ray_segment_nearest_hit.sv
